// ----- src/dpfw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package dpfw_pkg;

    // register indexes
    localparam logic [2:0] REG_ROW_X  = 3'd0;
    localparam logic [2:0] REG_ROW_Y  = 3'd1;
    localparam logic [2:0] REG_ROW_W  = 3'd2;
    localparam logic [2:0] REG_WIDTH  = 3'd3;
    localparam logic [2:0] REG_HEIGHT = 3'd4;

    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 3;
    localparam int DIM_W    = 11;
    localparam int COORD_W  = 10;
    localparam int DEPTH_W  = 16;
    localparam int PIX_W    = 8;
    localparam int LANE_W   = 16;
    localparam int PT_W     = 19;   // row<<8 as signed
    localparam int PROD_W   = LANE_W + PT_W;
    localparam int SUM_W    = 38;   // |sum| < 2^37
    localparam int QMAX     = 13;   // quotient bits for bounds up to 8192

    localparam logic [CFG_W-1:0] ROW_X_RST = 64'd256;
    localparam logic [CFG_W-1:0] ROW_Y_RST = 64'd1 << 24;
    localparam logic [CFG_W-1:0] ROW_W_RST = 64'd1 << 40;
    localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd480;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_COEF_BITS  = 16;

    // divider pipeline payload
    typedef struct packed {
        logic             vld;
        logic             drop;
        logic             negx;
        logic             negy;
        logic [SUM_W-1:0] remx;
        logic [SUM_W-1:0] remy;
        logic [SUM_W-1:0] dvs;
        logic [QMAX-1:0]  qx;
        logic [QMAX-1:0]  qy;
        logic [PIX_W-1:0] pix;
    } div_t;

endpackage
`default_nettype wire

// ----- src/dpfw_dot.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Two-stage dot product of one transform row with the point:
// products registered, then the four-term sum registered.
module dpfw_dot #(
    parameter int COEF_BITS = dpfw_pkg::DEF_COEF_BITS
) (
    input  wire logic                               aclk,
    input  wire logic                               en,
    input  wire logic [dpfw_pkg::CFG_W-1:0]         coefs,
    input  wire logic signed [dpfw_pkg::PT_W-1:0]   pt0,
    input  wire logic signed [dpfw_pkg::PT_W-1:0]   pt1,
    input  wire logic signed [dpfw_pkg::PT_W-1:0]   pt2,
    input  wire logic signed [dpfw_pkg::PT_W-1:0]   pt3,
    output logic signed [dpfw_pkg::SUM_W-1:0]       sum
);
    localparam int SH = dpfw_pkg::LANE_W - COEF_BITS;

    logic signed [dpfw_pkg::PROD_W-1:0] prod_reg [4];
    logic signed [dpfw_pkg::PROD_W-1:0] prod_next [4];
    logic signed [dpfw_pkg::SUM_W-1:0]  sum_reg;
    logic signed [dpfw_pkg::SUM_W-1:0]  sum_next;
    logic signed [dpfw_pkg::LANE_W-1:0] coef [4];
    logic signed [dpfw_pkg::PT_W-1:0]   pt [4];

    always_comb begin
        pt[0] = pt0;
        pt[1] = pt1;
        pt[2] = pt2;
        pt[3] = pt3;
        for (int i = 0; i < 4; i++) begin
            // keep low COEF_BITS of the lane, sign extended
            coef[i] = signed'(coefs[dpfw_pkg::LANE_W*i +: dpfw_pkg::LANE_W] << SH) >>> SH;
            prod_next[i] = dpfw_pkg::PROD_W'(coef[i]) * dpfw_pkg::PROD_W'(pt[i]);
        end
        sum_next = dpfw_pkg::SUM_W'(prod_reg[0]) + dpfw_pkg::SUM_W'(prod_reg[1])
                 + dpfw_pkg::SUM_W'(prod_reg[2]) + dpfw_pkg::SUM_W'(prod_reg[3]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            sum_reg  <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule
`default_nettype wire

// ----- src/dpfw_div_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// One restoring-division stage: resolves quotient bit K for both ratios.
module dpfw_div_step #(
    parameter int K = 0
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire dpfw_pkg::div_t din,
    output dpfw_pkg::div_t      dout
);
    localparam int CW = dpfw_pkg::SUM_W + dpfw_pkg::QMAX;

    dpfw_pkg::div_t   st_reg;
    dpfw_pkg::div_t   st_next;
    logic [CW-1:0]    dsh;
    logic             gex;
    logic             gey;

    always_comb begin
        dsh = CW'(din.dvs) << K;
        gex = CW'(din.remx) >= dsh;
        gey = CW'(din.remy) >= dsh;
        st_next = din;
        // remainder stays below dvs<<(K+1), so the subtraction fits SUM_W
        if (gex) begin
            st_next.remx = din.remx - dsh[dpfw_pkg::SUM_W-1:0];
        end
        if (gey) begin
            st_next.remy = din.remy - dsh[dpfw_pkg::SUM_W-1:0];
        end
        st_next.qx[K] = gex;
        st_next.qy[K] = gey;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.vld <= 1'b0;
        end else if (en) begin
            st_reg.vld <= st_next.vld;
        end
        if (en) begin
            st_reg.drop <= st_next.drop;
            st_reg.negx <= st_next.negx;
            st_reg.negy <= st_next.negy;
            st_reg.remx <= st_next.remx;
            st_reg.remy <= st_next.remy;
            st_reg.dvs  <= st_next.dvs;
            st_reg.qx   <= st_next.qx;
            st_reg.qy   <= st_next.qy;
            st_reg.pix  <= st_next.pix;
        end
    end

    assign dout = st_reg;

endmodule
`default_nettype wire

// ----- src/depth_pixel_forward_warp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Pipeline stages in order: products, sums, magnitudes, one stage per quotient bit
// of the divider, output register.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset (aresetn, synchronous, active low) clears all valid bits and loads the
// default transform and image size.
module depth_pixel_forward_warp #(
    parameter int MAX_WIDTH  = dpfw_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dpfw_pkg::DEF_MAX_HEIGHT,
    parameter int COEF_BITS  = dpfw_pkg::DEF_COEF_BITS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [dpfw_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  wire logic [dpfw_pkg::CFG_W-1:0]        cfg_wdata,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [dpfw_pkg::COORD_W-1:0]      s_src_row,
    input  wire logic [dpfw_pkg::COORD_W-1:0]      s_src_col,
    input  wire logic signed [dpfw_pkg::DEPTH_W-1:0] s_depth_value,
    input  wire logic [dpfw_pkg::PIX_W-1:0]        s_pixel_value,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [dpfw_pkg::COORD_W-1:0]           m_dest_col,
    output logic [dpfw_pkg::COORD_W-1:0]           m_dest_row,
    output logic [dpfw_pkg::PIX_W-1:0]             m_dest_pixel
);
    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int QB      = $clog2(MAX_DIM);
    localparam int CW      = dpfw_pkg::SUM_W + dpfw_pkg::QMAX;
    localparam int BW      = dpfw_pkg::QMAX + 2;

    logic [dpfw_pkg::CFG_W-1:0] row_x_reg, row_y_reg, row_w_reg;
    logic [dpfw_pkg::DIM_W-1:0] width_reg, height_reg;

    logic en;
    logic v1_reg, v2_reg;
    logic [dpfw_pkg::PIX_W-1:0] p1_reg, p2_reg;
    logic signed [dpfw_pkg::PT_W-1:0] pt0, pt1, pt2, pt3;
    logic signed [dpfw_pkg::SUM_W-1:0] sx, sy, sw;

    dpfw_pkg::div_t d3_reg, d3_next;
    dpfw_pkg::div_t dv [QB+1];
    dpfw_pkg::div_t fin;

    logic [dpfw_pkg::SUM_W-1:0] ax, ay, aw;
    logic [CW-1:0] wsh;
    logic ok;
    logic m_valid_reg;
    logic [dpfw_pkg::COORD_W-1:0] col_reg, row_reg;
    logic [dpfw_pkg::PIX_W-1:0] pix_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_x_reg  <= dpfw_pkg::ROW_X_RST;
            row_y_reg  <= dpfw_pkg::ROW_Y_RST;
            row_w_reg  <= dpfw_pkg::ROW_W_RST;
            width_reg  <= dpfw_pkg::WIDTH_RST;
            height_reg <= dpfw_pkg::HEIGHT_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                dpfw_pkg::REG_ROW_X:  row_x_reg  <= cfg_wdata;
                dpfw_pkg::REG_ROW_Y:  row_y_reg  <= cfg_wdata;
                dpfw_pkg::REG_ROW_W:  row_w_reg  <= cfg_wdata;
                dpfw_pkg::REG_WIDTH:  width_reg  <= cfg_wdata[dpfw_pkg::DIM_W-1:0];
                dpfw_pkg::REG_HEIGHT: height_reg <= cfg_wdata[dpfw_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    assign pt0 = signed'({1'b0, s_src_row, 8'd0});
    assign pt1 = signed'({1'b0, s_src_col, 8'd0});
    assign pt2 = dpfw_pkg::PT_W'(s_depth_value);
    assign pt3 = dpfw_pkg::PT_W'(256);

    dpfw_dot #(.COEF_BITS(COEF_BITS)) u_dot_x (
        .aclk(aclk), .en(en), .coefs(row_x_reg),
        .pt0(pt0), .pt1(pt1), .pt2(pt2), .pt3(pt3), .sum(sx));
    dpfw_dot #(.COEF_BITS(COEF_BITS)) u_dot_y (
        .aclk(aclk), .en(en), .coefs(row_y_reg),
        .pt0(pt0), .pt1(pt1), .pt2(pt2), .pt3(pt3), .sum(sy));
    dpfw_dot #(.COEF_BITS(COEF_BITS)) u_dot_w (
        .aclk(aclk), .en(en), .coefs(row_w_reg),
        .pt0(pt0), .pt1(pt1), .pt2(pt2), .pt3(pt3), .sum(sw));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
        end
        if (en) begin
            p1_reg <= s_pixel_value;
            p2_reg <= p1_reg;
        end
    end

    // magnitudes, signs, zero divisor and quotient overflow
    always_comb begin
        ax  = sx[dpfw_pkg::SUM_W-1] ? dpfw_pkg::SUM_W'(-sx) : dpfw_pkg::SUM_W'(sx);
        ay  = sy[dpfw_pkg::SUM_W-1] ? dpfw_pkg::SUM_W'(-sy) : dpfw_pkg::SUM_W'(sy);
        aw  = sw[dpfw_pkg::SUM_W-1] ? dpfw_pkg::SUM_W'(-sw) : dpfw_pkg::SUM_W'(sw);
        wsh = CW'(aw) << QB;
        d3_next.vld  = v2_reg;
        d3_next.drop = (aw == '0) || (CW'(ax) >= wsh) || (CW'(ay) >= wsh);
        d3_next.negx = sx[dpfw_pkg::SUM_W-1] ^ sw[dpfw_pkg::SUM_W-1];
        d3_next.negy = sy[dpfw_pkg::SUM_W-1] ^ sw[dpfw_pkg::SUM_W-1];
        d3_next.remx = ax;
        d3_next.remy = ay;
        d3_next.dvs  = aw;
        d3_next.qx   = '0;
        d3_next.qy   = '0;
        d3_next.pix  = p2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d3_reg.vld <= 1'b0;
        end else if (en) begin
            d3_reg.vld <= d3_next.vld;
        end
        if (en) begin
            d3_reg.drop <= d3_next.drop;
            d3_reg.negx <= d3_next.negx;
            d3_reg.negy <= d3_next.negy;
            d3_reg.remx <= d3_next.remx;
            d3_reg.remy <= d3_next.remy;
            d3_reg.dvs  <= d3_next.dvs;
            d3_reg.qx   <= d3_next.qx;
            d3_reg.qy   <= d3_next.qy;
            d3_reg.pix  <= d3_next.pix;
        end
    end

    assign dv[0] = d3_reg;

    for (genvar i = 0; i < QB; i++) begin : g_div
        dpfw_div_step #(.K(QB - 1 - i)) u_step (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .din(dv[i]), .dout(dv[i+1]));
    end

    assign fin = dv[QB];

    // negative nonzero quotient, or outside the image, drops the item
    always_comb begin
        ok = fin.vld && !fin.drop
            && !(fin.negx && fin.qx != '0) && !(fin.negy && fin.qy != '0)
            && (BW'(fin.qx) < BW'(width_reg))  && (32'(fin.qx) < MAX_WIDTH)
            && (BW'(fin.qy) < BW'(height_reg)) && (32'(fin.qy) < MAX_HEIGHT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= ok;
        end
        if (en) begin
            col_reg <= fin.qx[dpfw_pkg::COORD_W-1:0];
            row_reg <= fin.qy[dpfw_pkg::COORD_W-1:0];
            pix_reg <= fin.pix;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_dest_col   = col_reg;
    assign m_dest_row   = row_reg;
    assign m_dest_pixel = pix_reg;

endmodule
`default_nettype wire

// ----- src/dpfw_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module dpfw_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [9:0] m_dest_col,
    input wire logic [9:0] m_dest_row,
    input wire logic [7:0] m_dest_pixel
);
    // pipeline advances exactly when the output slot is free or drains
    a_ready_tracks_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("s_ready does not follow output slot state");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_dest_col) && $stable(m_dest_row)
            && $stable(m_dest_pixel))
        else $error("result changed while stalled");

endmodule

bind depth_pixel_forward_warp dpfw_checker u_dpfw_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready), .m_valid(m_valid),
    .m_ready(m_ready), .m_dest_col(m_dest_col), .m_dest_row(m_dest_row),
    .m_dest_pixel(m_dest_pixel));
`default_nettype wire
